FILE: hw/rtl/bc_pkg.sv
// bc_pkg: shared constants, control word type and microcode table for the
// binomial coefficient unit. No dependencies.

package bc_pkg;

    // data widths
    localparam int MAX_N   = 62;
    localparam int N_W     = 6;
    localparam int K_W     = 5;
    localparam int ACC_W   = 64;
    localparam int RES_W   = 59;
    localparam int CNT_W   = 6;
    localparam int UPC_W   = 3;
    localparam int OP_W    = 3;
    localparam int COND_W  = 3;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NOP  = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INIT = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OP_W-1:0] OP_NEXT = 3'd5;
    localparam logic [OP_W-1:0] OP_EMIT = 3'd6;

    // jump conditions
    localparam logic [COND_W-1:0] C_NONE     = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] C_NO_IN    = 3'd2;
    localparam logic [COND_W-1:0] C_BAD      = 3'd3;
    localparam logic [COND_W-1:0] C_I_GT_K   = 3'd4;
    localparam logic [COND_W-1:0] C_DIV_BUSY = 3'd5;
    localparam logic [COND_W-1:0] C_OUT_BUSY = 3'd6;

    // program step addresses
    localparam logic [UPC_W-1:0] S_IDLE = 3'd0;
    localparam logic [UPC_W-1:0] S_INIT = 3'd1;
    localparam logic [UPC_W-1:0] S_TEST = 3'd2;
    localparam logic [UPC_W-1:0] S_MUL  = 3'd3;
    localparam logic [UPC_W-1:0] S_DIV  = 3'd4;
    localparam logic [UPC_W-1:0] S_NEXT = 3'd5;
    localparam logic [UPC_W-1:0] S_EMIT = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [UPC_W-1:0]  target;
    } t_uword;

    // microcode rom: jump to target when cond holds, else step + 1 (wraps)
    function automatic t_uword f_urom(input logic [UPC_W-1:0] addr);
        t_uword w;
        unique case (addr)
            S_IDLE:  w = '{op: OP_LOAD, cond: C_NO_IN,    target: S_IDLE};
            S_INIT:  w = '{op: OP_INIT, cond: C_BAD,      target: S_EMIT};
            S_TEST:  w = '{op: OP_NOP,  cond: C_I_GT_K,   target: S_EMIT};
            S_MUL:   w = '{op: OP_MUL,  cond: C_NONE,     target: S_IDLE};
            S_DIV:   w = '{op: OP_DIV,  cond: C_DIV_BUSY, target: S_DIV};
            S_NEXT:  w = '{op: OP_NEXT, cond: C_ALWAYS,   target: S_TEST};
            S_EMIT:  w = '{op: OP_EMIT, cond: C_OUT_BUSY, target: S_EMIT};
            default: w = '{op: OP_NOP,  cond: C_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/binomial_coefficient.sv
// binomial_coefficient: n choose r by a microcoded multiply / exact-divide loop.
// Depends on bc_pkg (widths, control word, microcode table).
//
//   channel | handshake                 | payload
//   --------+---------------------------+-----------------------
//   in      | i_in_valid / o_in_stall   | i_n[5:0], i_r[5:0]
//   out     | o_out_valid / i_out_stall | o_result[58:0]
//
// One item runs k = min(r, n-r) loop steps from input transfer to result; each
// step multiplies, then divides exactly with the bit-serial divider, which dominates it.
// Out-of-range pairs (n above 62 or r above n) skip the loop and return zero.
// Reset is synchronous and clears the step counter and the output valid.
// A new item is taken once the result is in the output register, even while it
// is stalled; a result waits in the final step only if that register is still full.

module binomial_coefficient
    import bc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [N_W-1:0]   i_n,
    input  logic [N_W-1:0]   i_r,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [RES_W-1:0] o_result
);

    logic [UPC_W-1:0] r_upc, n_upc;
    logic [N_W-1:0]   r_n, r_r;
    logic [K_W-1:0]   r_k;
    logic [N_W-1:0]   r_i;
    logic [ACC_W-1:0] r_acc;
    logic [K_W-1:0]   r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic [RES_W-1:0] r_result;

    t_uword             uw;
    logic               in_xfer;
    logic               out_busy;
    logic               bad;
    logic               jump;
    logic [N_W-1:0]     k_full;
    logic [N_W-1:0]     factor;
    logic [ACC_W+N_W-1:0] prod;
    logic [N_W-1:0]     trial;
    logic               q_bit;
    logic [N_W-1:0]     trial_sub;

    // control word of the current step
    assign uw       = f_urom(r_upc);
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_busy = r_out_valid && i_out_stall;

    // range check and symmetry
    assign bad    = (r_n > N_W'(MAX_N)) || (r_r > r_n);
    assign k_full = (r_r > (r_n >> 1)) ? (r_n - r_r) : r_r;

    // multiply operand and product
    assign factor = r_n - {1'b0, r_k} + r_i;
    assign prod   = r_acc * factor;

    // one restoring division step
    assign trial     = {r_rem, r_acc[ACC_W-1]};
    assign q_bit     = (trial >= r_i);
    assign trial_sub = q_bit ? (trial - r_i) : trial;

    // jump condition select
    always_comb begin
        unique case (uw.cond)
            C_NONE:     jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_IN:    jump = !in_xfer;
            C_BAD:      jump = bad;
            C_I_GT_K:   jump = (r_i > {1'b0, r_k});
            C_DIV_BUSY: jump = (r_cnt != {CNT_W{1'b1}});
            C_OUT_BUSY: jump = out_busy;
            default:    jump = 1'b1;
        endcase
        n_upc = jump ? uw.target : r_upc + 1'b1;
    end

    // step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_upc <= n_upc;
            if (uw.op == OP_EMIT && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (uw.op)
            OP_LOAD: begin
                if (in_xfer) begin
                    r_n <= i_n;
                    r_r <= i_r;
                end
            end
            OP_INIT: begin
                r_k   <= k_full[K_W-1:0];
                r_i   <= N_W'(1);
                r_acc <= bad ? '0 : ACC_W'(1);
            end
            OP_MUL: begin
                r_acc <= prod[ACC_W-1:0];
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV: begin
                r_acc <= {r_acc[ACC_W-2:0], q_bit};
                r_rem <= trial_sub[K_W-1:0];
                r_cnt <= r_cnt + 1'b1;
            end
            OP_NEXT: begin
                r_i <= r_i + 1'b1;
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    r_result <= r_acc[RES_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall  = (r_upc != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

FILE: hw/rtl/bc_check.sv
// bc_check: port-level checks for binomial_coefficient, and the bind that attaches it.
// Depends on nothing but the top level's ports.

module bc_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [58:0] o_result
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result))
        else $error("stalled result changed");

    // an input transfer makes the block busy
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("no busy after input transfer");

    // a new result appears only as the block returns to idle
    a_out_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("result raised while busy");

    // reset leaves the block idle and empty
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset state wrong");

endmodule

bind binomial_coefficient bc_check u_bc_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_result    (o_result)
);
